// ===== src/direct_form_iir_filter_defines.svh =====
// Assertion macros for the direct-form IIR filter.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef DIRECT_FORM_IIR_FILTER_DEFINES_SVH
`define DIRECT_FORM_IIR_FILTER_DEFINES_SVH

// Check a property on every clock edge out of reset.
`define DFIIR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define DFIIR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/dfiir_pkg.sv =====
// Shared types, constants and register codes for the direct-form IIR filter.
// No dependencies.
package dfiir_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 18;
    localparam int HIST_DEPTH = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int FRAC_SHIFT = 14;

    localparam int FF_TAPS_DEF = 4;
    localparam int FB_TAPS_DEF = 3;

    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_FF_COEF_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEF_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEF_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEF_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEF_1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEF_2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEF_3 = 3'd6;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;

    // Q3.14 value of 1.0
    localparam coef_t COEF_ONE = 18'sd16384;

    typedef struct packed {
        logic    cmd;
        sample_t sample;
    } iir_in_t;

    typedef struct packed {
        sample_t filtered;
        logic    saturated;
    } iir_out_t;

    // ff[0] is the current-input tap; fb[k] is the tap for output k+1 back.
    typedef struct packed {
        coef_t [3:0]            ff;
        coef_t [HIST_DEPTH-1:0] fb;
    } coef_set_t;

    // Index 0 holds the newest entry.
    typedef struct packed {
        sample_t [HIST_DEPTH-1:0] x;
        sample_t [HIST_DEPTH-1:0] y;
    } hist_t;

endpackage

// ===== src/direct_form_iir_filter.sv =====
// Direct-form I IIR filter top level: request register, histories, result register.
// Depends on dfiir_pkg, dfiir_coef_regs, dfiir_datapath and the defines header.
//
//   channel   direction  handshake                  payload
//   item      in         item_valid / item_ready    iir_in_t  (cmd, sample)
//   result    out        result_valid / result_ready iir_out_t (filtered, saturated)
//   cfg       in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One request per cycle unless results stall; requests and results are registered.
// The loop from the output history through multiply, sum and saturation back into the
// history sets the cycle time.
// Reset loads ff_coef_0 = 1.0, other coefficients zero, histories zero; no clearing pass.
// A stalled result holds the request register; a clear request advances past a stall.
`include "direct_form_iir_filter_defines.svh"

module direct_form_iir_filter
    import dfiir_pkg::*;
#(
    parameter int FF_TAPS = FF_TAPS_DEF,
    parameter int FB_TAPS = FB_TAPS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  iir_in_t              item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output iir_out_t             result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data
);

    logic      in_valid_reg;
    iir_in_t   in_data_reg;
    logic      out_valid_reg;
    iir_out_t  out_data_reg;
    hist_t     hist_reg;
    hist_t     hist_next;
    coef_set_t coefs;
    iir_out_t  dp_result;
    logic      advance;
    logic      is_clear;
    logic      adv_filter;
    logic      adv_clear;
    logic      hist_match;
    logic      at_rail;

    assign cfg_ready = 1'b1;

    dfiir_coef_regs u_coef_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coefs     (coefs)
    );

    dfiir_datapath #(
        .FF_TAPS (FF_TAPS),
        .FB_TAPS (FB_TAPS)
    ) u_datapath (
        .sample (in_data_reg.sample),
        .hist   (hist_reg),
        .coefs  (coefs),
        .result (dp_result)
    );

    assign is_clear   = (in_data_reg.cmd == CMD_CLEAR);
    assign advance    = in_valid_reg && (is_clear || !out_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item_valid && item_ready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            in_data_reg <= item;
    end

    always_comb
    begin
        hist_next = hist_reg;
        if (advance)
        begin
            if (is_clear)
                hist_next = '0;
            else
            begin
                for (int k = HIST_DEPTH - 1; k > 0; k--)
                begin
                    hist_next.x[k] = hist_reg.x[k-1];
                    hist_next.y[k] = hist_reg.y[k-1];
                end
                hist_next.x[0] = in_data_reg.sample;
                hist_next.y[0] = dp_result.filtered;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hist_reg <= '0;
        else
            hist_reg <= hist_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && !is_clear)
            out_valid_reg <= 1'b1;
        else if (result_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && !is_clear)
            out_data_reg <= dp_result;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    assign adv_filter = advance && !is_clear;
    assign adv_clear  = advance && is_clear;
    assign hist_match = (hist_reg.y[0] == result.filtered);
    assign at_rail    = (result.filtered == sample_t'(SAMPLE_MAX))
                        || (result.filtered == sample_t'(SAMPLE_MIN));

    `DFIIR_ASSERT(a_clear_zeroes_hist, adv_clear |=> (hist_reg == '0), "clear left history")
    `DFIIR_ASSERT(a_result_in_hist, adv_filter |=> (result_valid && hist_match), "history mismatch")
    `DFIIR_ASSERT(a_sat_at_rail, (result_valid && result.saturated) |-> at_rail, "sat off rail")
    `DFIIR_ASSERT_ALWAYS(a_ready_when_empty, !in_valid_reg |-> item_ready, "empty not ready")

endmodule

// ===== src/dfiir_coef_regs.sv =====
// Coefficient register file written through the configuration channel.
// Depends on dfiir_pkg.
module dfiir_coef_regs
    import dfiir_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data,
    output coef_set_t            coefs
);

    localparam coef_set_t COEF_RESET = {{3{coef_t'(0)}}, COEF_ONE, {HIST_DEPTH{coef_t'(0)}}};

    coef_set_t coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= COEF_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FF_COEF_0: coef_reg.ff[0] <= coef_t'(cfg_data);
                REG_FF_COEF_1: coef_reg.ff[1] <= coef_t'(cfg_data);
                REG_FF_COEF_2: coef_reg.ff[2] <= coef_t'(cfg_data);
                REG_FF_COEF_3: coef_reg.ff[3] <= coef_t'(cfg_data);
                REG_FB_COEF_1: coef_reg.fb[0] <= coef_t'(cfg_data);
                REG_FB_COEF_2: coef_reg.fb[1] <= coef_t'(cfg_data);
                REG_FB_COEF_3: coef_reg.fb[2] <= coef_t'(cfg_data);
                default:       coef_reg       <= coef_reg;
            endcase
        end
    end

    assign coefs = coef_reg;

endmodule

// ===== src/dfiir_datapath.sv =====
// Multiply-accumulate, rounding and saturation for one filter sample.
// Depends on dfiir_pkg.
module dfiir_datapath
    import dfiir_pkg::*;
#(
    parameter int FF_TAPS = FF_TAPS_DEF,
    parameter int FB_TAPS = FB_TAPS_DEF
)
(
    input  sample_t   sample,
    input  hist_t     hist,
    input  coef_set_t coefs,
    output iir_out_t  result
);

    localparam int N_TERMS = (FF_TAPS + FB_TAPS > 1) ? FF_TAPS + FB_TAPS : 1;
    localparam int ACC_W   = PROD_W + $clog2(N_TERMS);
    localparam int Q_W     = ACC_W - FRAC_SHIFT;

    logic signed [PROD_W-1:0] ff_prod [FF_TAPS];
    logic signed [PROD_W-1:0] fb_prod [HIST_DEPTH];
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  acc_rnd;
    logic signed [Q_W-1:0]    q;

    always_comb
    begin
        for (int k = 0; k < FF_TAPS; k++)
        begin
            if (k == 0)
                ff_prod[k] = PROD_W'(sample * coefs.ff[k]);
            else
                ff_prod[k] = PROD_W'(hist.x[k-1] * coefs.ff[k]);
        end
        for (int k = 0; k < HIST_DEPTH; k++)
            fb_prod[k] = PROD_W'(hist.y[k] * coefs.fb[k]);
    end

    always_comb
    begin
        acc = '0;
        for (int k = 0; k < FF_TAPS; k++)
            acc = acc + ACC_W'(ff_prod[k]);
        for (int k = 0; k < FB_TAPS; k++)
            acc = acc - ACC_W'(fb_prod[k]);
    end

    // round half up, then floor shift
    assign acc_rnd = acc + ACC_W'(1 << (FRAC_SHIFT - 1));
    assign q       = acc_rnd[ACC_W-1:FRAC_SHIFT];

    always_comb
    begin
        if (q > Q_W'(SAMPLE_MAX))
        begin
            result.filtered  = sample_t'(SAMPLE_MAX);
            result.saturated = 1'b1;
        end
        else if (q < Q_W'(SAMPLE_MIN))
        begin
            result.filtered  = sample_t'(SAMPLE_MIN);
            result.saturated = 1'b1;
        end
        else
        begin
            result.filtered  = sample_t'(q);
            result.saturated = 1'b0;
        end
    end

endmodule
